// ===== rtl/core/sdtq_pkg.sv =====
// sdtq_pkg: shared types and constants of the sorted deadline timer queue
// operation codes, slot record, cell control bundle and sequencer states
// no dependencies
package sdtq_pkg;

  localparam int OP_W      = 2;
  localparam int ID_W      = 8;
  localparam int ID_SPAN   = 1 << ID_W;
  localparam int DELAY_W   = 24;
  localparam int DL_W      = 48;
  localparam int MAX_OUT   = 16;
  localparam int FIRE_IDX_W = $clog2(MAX_OUT);
  localparam int FIRE_CNT_W = $clog2(MAX_OUT + 1);

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_TICK    = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_DEL  = 2'd1,
    CELL_INS  = 2'd2
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_INS  = 3'd1,
    ST_POP  = 3'd2,
    ST_RESP = 3'd3,
    ST_EMIT = 3'd4
  } state_t;

  typedef struct packed {
    logic            valid;
    logic [DL_W-1:0] deadline;
    logic [ID_W-1:0] owner;
  } slot_t;

  typedef struct packed {
    cell_op_t           op;
    logic [DL_W-1:0]    now;
    logic [DELAY_W-1:0] key;
    logic [ID_W-1:0]    cmp_id;
    logic [DL_W-1:0]    new_deadline;
  } cell_ctl_t;

endpackage

// ===== rtl/core/sdtq_if.sv =====
// sdtq_in_if, sdtq_out_if: valid/ready channels of the timer queue
// each beat carries one command or one result; depends on sdtq_pkg
interface sdtq_in_if import sdtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [ID_W-1:0]    timer_id;
  logic [DELAY_W-1:0] delay_ms;

  modport source (output valid, output operation, output timer_id, output delay_ms,
                  input ready);
  modport sink (input valid, input operation, input timer_id, input delay_ms,
                output ready);
endinterface

interface sdtq_out_if import sdtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               expired_valid;
  logic [ID_W-1:0]    expired_id;
  logic               last;
  logic               is_armed;
  logic               has_next;
  logic [DELAY_W-1:0] time_to_next;
  logic               status;

  modport source (output valid, output expired_valid, output expired_id, output last,
                  output is_armed, output has_next, output time_to_next, output status,
                  input ready);
  modport sink (input valid, input expired_valid, input expired_id, input last,
                input is_armed, input has_next, input time_to_next, input status,
                output ready);
endinterface

// ===== rtl/core/sdtq_cell.sv =====
// sdtq_cell: one slot of the sorted timer chain
// holds a deadline and owner, shifts left on delete and right on insert
// depends on sdtq_pkg
module sdtq_cell import sdtq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      shift_en,
  input  slot_t     left_slot,
  input  logic      left_stay,
  input  slot_t     right_slot,
  output slot_t     slot,
  output logic      stay,
  output logic      hit
);

  logic            valid_r, valid_nxt;
  logic [DL_W-1:0] deadline_r, deadline_nxt;
  logic [ID_W-1:0] owner_r, owner_nxt;
  logic [DL_W-1:0] ahead;

  assign ahead = deadline_r - ctl.now;
  // entry sorts at or before the new key
  assign stay = valid_r && (ahead[DL_W-1:DELAY_W] == '0) && (ahead[DELAY_W-1:0] <= ctl.key);
  assign hit  = valid_r && (owner_r == ctl.cmp_id);

  assign slot.valid    = valid_r;
  assign slot.deadline = deadline_r;
  assign slot.owner    = owner_r;

  always_comb begin
    valid_nxt    = valid_r;
    deadline_nxt = deadline_r;
    owner_nxt    = owner_r;
    unique case (ctl.op)
      CELL_DEL: begin
        if (shift_en) begin
          valid_nxt    = right_slot.valid;
          deadline_nxt = right_slot.deadline;
          owner_nxt    = right_slot.owner;
        end
      end
      CELL_INS: begin
        if (!stay) begin
          if (left_stay) begin
            valid_nxt    = 1'b1;
            deadline_nxt = ctl.new_deadline;
            owner_nxt    = ctl.cmp_id;
          end else begin
            valid_nxt    = left_slot.valid;
            deadline_nxt = left_slot.deadline;
            owner_nxt    = left_slot.owner;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    owner_r    <= owner_nxt;
  end

endmodule

// ===== rtl/core/sorted_deadline_timer_queue_core.sv =====
// sorted_deadline_timer_queue_core: top level of the sorted timer queue
// a row of sdtq_cell slots, the command sequencer and the result register
// depends on sdtq_pkg, sdtq_if and sdtq_cell
//
// Keeps up to SLOTS one-shot timers sorted by deadline beside a 48-bit millisecond
// counter. One command beat is taken at a time; the row of cells moves by one
// place per cycle. Cancels, queries and rejected requests respond directly; an
// accepted request is inserted first; a tick pops due timers in turn, at most 16
// per tick, then gives a result beat per fired timer. Results sit in an output
// register, so a new command is taken while the last result still waits; its
// own result then waits until that register is free. Timer ids are reduced modulo
// ID_COUNT. Slot contents need no clearing after reset; only valid slots are read.
module sorted_deadline_timer_queue_core import sdtq_pkg::*; #(
  parameter int SLOTS    = 16,
  parameter int ID_COUNT = 256
) (
  input logic        clk,
  input logic        rst_n,
  sdtq_in_if.sink    in_ch,
  sdtq_out_if.source out_ch
);

  state_t             state_r, state_nxt;
  logic [DL_W-1:0]    now_r, now_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic               status_r, status_nxt;
  logic [FIRE_CNT_W-1:0] fire_cnt_r, fire_cnt_nxt;
  logic [FIRE_IDX_W-1:0] emit_idx_r, emit_idx_nxt;
  logic [ID_W-1:0]    fired_mem [MAX_OUT];
  logic               fire_we;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic [ID_W-1:0]    out_eid_r, out_eid_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_armed_r, out_armed_nxt;
  logic               out_next_r, out_next_nxt;
  logic [DELAY_W-1:0] out_ttn_r, out_ttn_nxt;
  logic               out_status_r, out_status_nxt;

  logic [ID_W-1:0]    id_tbl [ID_SPAN];
  logic [ID_W-1:0]    in_id_mod;
  cell_ctl_t          ctl;
  cell_op_t           cell_op;
  slot_t              slots [SLOTS];
  logic [SLOTS-1:0]   stay_vec, hit_vec, shift_vec;
  logic [SLOTS:0]     valid_ext;
  logic               any_hit, full, head_due, out_free, accept, pop_mode, emit_last;
  logic [DL_W-1:0]    head_dist;
  logic [DELAY_W-1:0] ttn;

  // id reduction table
  for (genvar t = 0; t < ID_SPAN; t++) begin : g_id_tbl
    assign id_tbl[t] = ID_W'(t % ID_COUNT);
  end

  assign in_id_mod = id_tbl[in_ch.timer_id];

  assign ctl.op           = cell_op;
  assign ctl.now          = now_r;
  assign ctl.key          = delay_r;
  assign ctl.cmp_id       = (state_r == ST_IDLE) ? in_id_mod : id_r;
  assign ctl.new_deadline = now_r + {{(DL_W-DELAY_W){1'b0}}, delay_r};

  assign pop_mode = (state_r == ST_POP);

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    slot_t left_s, right_s;
    logic  left_st;
    if (g == 0) begin : g_head
      assign left_s  = '0;
      assign left_st = 1'b1;
    end else begin : g_mid
      assign left_s  = slots[g-1];
      assign left_st = stay_vec[g-1];
    end
    if (g == SLOTS - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_body
      assign right_s = slots[g+1];
    end
    assign shift_vec[g] = pop_mode | (|hit_vec[g:0]);
    assign valid_ext[g] = slots[g].valid;

    sdtq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .shift_en   (shift_vec[g]),
      .left_slot  (left_s),
      .left_stay  (left_st),
      .right_slot (right_s),
      .slot       (slots[g]),
      .stay       (stay_vec[g]),
      .hit        (hit_vec[g])
    );
  end

  assign valid_ext[SLOTS] = 1'b0;

  assign any_hit   = |hit_vec;
  assign full      = slots[SLOTS-1].valid;
  assign head_dist = slots[0].deadline - now_r;
  assign head_due  = slots[0].valid && ((head_dist == '0) || head_dist[DL_W-1]);
  assign ttn       = (!slots[0].valid || head_dist[DL_W-1]) ? '0 : head_dist[DELAY_W-1:0];
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept    = in_ch.valid && in_ch.ready;
  assign emit_last = ({1'b0, emit_idx_r} + 1'b1) == fire_cnt_r;

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    id_nxt         = id_r;
    delay_nxt      = delay_r;
    status_nxt     = status_r;
    fire_cnt_nxt   = fire_cnt_r;
    emit_idx_nxt   = emit_idx_r;
    fire_we        = 1'b0;
    cell_op        = CELL_HOLD;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_ev_nxt     = out_ev_r;
    out_eid_nxt    = out_eid_r;
    out_last_nxt   = out_last_r;
    out_armed_nxt  = out_armed_r;
    out_next_nxt   = out_next_r;
    out_ttn_nxt    = out_ttn_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          id_nxt     = in_id_mod;
          delay_nxt  = in_ch.delay_ms;
          status_nxt = 1'b0;
          unique case (op_t'(in_ch.operation))
            OP_REQUEST: begin
              if (!any_hit && full) begin
                status_nxt = 1'b1;
                state_nxt  = ST_RESP;
              end else begin
                if (any_hit) begin
                  cell_op = CELL_DEL;
                end
                state_nxt = ST_INS;
              end
            end
            OP_CANCEL: begin
              cell_op   = CELL_DEL;
              state_nxt = ST_RESP;
            end
            OP_TICK: begin
              now_nxt      = now_r + 1'b1;
              fire_cnt_nxt = '0;
              state_nxt    = ST_POP;
            end
            OP_QUERY: begin
              state_nxt = ST_RESP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_INS: begin
        cell_op   = CELL_INS;
        state_nxt = ST_RESP;
      end
      ST_POP: begin
        if ((fire_cnt_r != FIRE_CNT_W'(MAX_OUT)) && head_due) begin
          cell_op      = CELL_DEL;
          fire_we      = 1'b1;
          fire_cnt_nxt = fire_cnt_r + 1'b1;
        end else if (fire_cnt_r == '0) begin
          state_nxt = ST_RESP;
        end else begin
          emit_idx_nxt = '0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_ev_nxt     = 1'b0;
          out_eid_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_armed_nxt  = any_hit;
          out_next_nxt   = slots[0].valid;
          out_ttn_nxt    = ttn;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_ev_nxt     = 1'b1;
          out_eid_nxt    = fired_mem[emit_idx_r];
          out_last_nxt   = emit_last;
          out_armed_nxt  = any_hit;
          out_next_nxt   = slots[0].valid;
          out_ttn_nxt    = ttn;
          out_status_nxt = 1'b0;
          emit_idx_nxt   = emit_idx_r + 1'b1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      fire_cnt_r  <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    delay_r      <= delay_nxt;
    status_r     <= status_nxt;
    out_ev_r     <= out_ev_nxt;
    out_eid_r    <= out_eid_nxt;
    out_last_r   <= out_last_nxt;
    out_armed_r  <= out_armed_nxt;
    out_next_r   <= out_next_nxt;
    out_ttn_r    <= out_ttn_nxt;
    out_status_r <= out_status_nxt;
    if (fire_we) begin
      fired_mem[fire_cnt_r[FIRE_IDX_W-1:0]] <= slots[0].owner;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.expired_valid = out_ev_r;
  assign out_ch.expired_id    = out_eid_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.is_armed      = out_armed_r;
  assign out_ch.has_next      = out_next_r;
  assign out_ch.time_to_next  = out_ttn_r;
  assign out_ch.status        = out_status_r;

  // valid slots always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_ext + 1'b1) & valid_ext) == '0)
    else $error("valid slots are not a prefix");

  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= FIRE_CNT_W'(MAX_OUT))
    else $error("fired count beyond limit");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ({1'b0, emit_idx_r} < fire_cnt_r))
    else $error("emit index past fired count");

  a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.operation == OP_TICK)) |=> (now_r == $past(now_r) + 1'b1))
    else $error("tick did not advance the clock");

endmodule
